>>> rtl/core/gfla_pkg.sv
// ----------------------------------------------------------------------------
// gfla_pkg
// shared types and constants of the gf(2^m) log/antilog arithmetic unit
// ----------------------------------------------------------------------------
package gfla_pkg;

   localparam int MAX_SYMBOL_BITS = 8;
   localparam int SYM_BITS        = 8;
   localparam int TBL_DEPTH       = 256;
   localparam int TBL_ADDR_BITS   = 8;
   localparam int POLY_BITS       = 9;
   localparam int WIDTH_BITS      = 4;
   localparam int CSR_INDEX_BITS  = 4;

   // configuration register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FIELD_POLYNOMIAL = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SYMBOL_BITS      = 4'd1;

   typedef enum logic [1:0] {
      CMD_MUL    = 2'd0,
      CMD_DIV    = 2'd1,
      CMD_LOAD   = 2'd2,
      CMD_HORNER = 2'd3
   } cmd_type;

   // table write port driven by the builder, plus its done flag
   typedef struct packed {
      logic                     log_we;
      logic [TBL_ADDR_BITS-1:0] log_addr;
      logic [SYM_BITS-1:0]      log_data;
      logic                     alog_we;
      logic [TBL_ADDR_BITS-1:0] alog_addr;
      logic [SYM_BITS-1:0]      alog_data;
      logic                     ready;
   } tbl_wr_type;

endpackage

>>> rtl/core/gfla_ram.sv
// ----------------------------------------------------------------------------
// gfla_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module gfla_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // read data holds while the reader is stalled
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/gfla_table_builder.sv
// ----------------------------------------------------------------------------
// gfla_table_builder
// fills the log and antilog tables from the field polynomial
// ----------------------------------------------------------------------------
module gfla_table_builder (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [gfla_pkg::SYM_BITS-1:0]  poly,
   input  logic [gfla_pkg::SYM_BITS-1:0]  ms,
   input  logic [2:0]                     top_bit,
   output gfla_pkg::tbl_wr_type           tbl_wr
);
   import gfla_pkg::*;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_SEQ,
      ST_LOG0,
      ST_DONE
   } state_type;

   state_type             state_ff, state_in;
   logic [SYM_BITS-1:0]   cnt_ff, cnt_in;
   logic [SYM_BITS-1:0]   x_ff, x_in;
   logic [SYM_BITS-1:0]   x_next;

   // next power of alpha: shift and reduce, kept to m bits
   assign x_next = ((x_ff << 1) & ms) ^ (x_ff[top_bit] ? poly : '0);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      x_in     = x_ff;
      tbl_wr   = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            tbl_wr.log_we    = 1'b1;
            tbl_wr.log_addr  = cnt_ff;
            tbl_wr.log_data  = '0;
            tbl_wr.alog_we   = 1'b1;
            tbl_wr.alog_addr = cnt_ff;
            tbl_wr.alog_data = SYM_BITS'(1);
            cnt_in           = cnt_ff + 1'b1;
            if (cnt_ff == SYM_BITS'(TBL_DEPTH - 1)) begin
               state_in = ST_SEQ;
               cnt_in   = SYM_BITS'(1);
               x_in     = SYM_BITS'(1);
            end
         end
         ST_SEQ: begin
            tbl_wr.alog_we   = 1'b1;
            tbl_wr.alog_addr = cnt_ff;
            tbl_wr.alog_data = x_next;
            tbl_wr.log_we    = 1'b1;
            tbl_wr.log_addr  = x_next;
            tbl_wr.log_data  = cnt_ff;
            x_in             = x_next;
            cnt_in           = cnt_ff + 1'b1;
            if (cnt_ff == ms - 1'b1) begin
               state_in = ST_LOG0;
            end
         end
         ST_LOG0: begin
            // zero maps to the top exponent, written last
            tbl_wr.log_we   = 1'b1;
            tbl_wr.log_addr = '0;
            tbl_wr.log_data = ms;
            state_in        = ST_DONE;
         end
         ST_DONE: begin
            tbl_wr.ready = 1'b1;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
      if (start) begin
         state_in = ST_CLEAR;
         cnt_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      x_ff <= x_in;
   end

endmodule

>>> rtl/core/gf_log_antilog_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// gf_log_antilog_arithmetic_unit
// gf(2^m) multiply, divide and horner evaluation over log/antilog tables
// ----------------------------------------------------------------------------
// usage:
//  - req channel: one item per command; req_tuser holds the command, req_tdata
//    the two symbols. rsp channel: one item per request with the value and the
//    divide by zero flag, in request order
//  - csr channel: writes the field polynomial (index 0) or the symbol width
//    (index 1); csr_ready is always high; other indexes are ignored
//  - after reset and after each write to index 0 or 1 the tables are rebuilt:
//    every entry is cleared, the powers of alpha are walked in sequence and
//    log 0 is written last; req_tready stays low meanwhile
//  - a request passes the issue stage, the log read, the antilog read and
//    the output register before its result shows on rsp
//  - throughput: one item per cycle while rsp does not stall; a horner step
//    that follows a load or another horner step waits for the accumulator,
//    which passes the log read and the antilog read
//  - rsp stall: the output register holds the result, the pipeline freezes,
//    and one more request is still taken into the issue stage
// ----------------------------------------------------------------------------
module gf_log_antilog_arithmetic_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   // csr write channel
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [gfla_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [gfla_pkg::POLY_BITS-1:0]       csr_wdata,
   // request stream
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [15:0]                          req_tdata,  // operand_a, operand_b
   input  logic [1:0]                           req_tuser,  // command
   // result stream
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [7:0]                           rsp_tdata,  // value
   output logic                                 rsp_tuser   // divide_by_zero
);
   import gfla_pkg::*;

   // configuration
   logic [POLY_BITS-1:0]  poly_ff, poly_in;
   logic [WIDTH_BITS-1:0] sym_ff, sym_in;
   logic                  restart;
   logic [WIDTH_BITS-1:0] m_w;
   logic [WIDTH_BITS-1:0] m_less1;
   logic [SYM_BITS:0]     ms_full;
   logic [SYM_BITS-1:0]   ms;

   tbl_wr_type tbl_wr;

   // horner accumulator
   logic [SYM_BITS-1:0] acc_ff, acc_in;
   logic [SYM_BITS-1:0] acc_m;

   // issue stage
   logic                p0_valid_ff, p0_valid_in;
   cmd_type             p0_cmd_ff, p0_cmd_in;
   logic [SYM_BITS-1:0] p0_a_ff, p0_a_in;
   logic [SYM_BITS-1:0] p0_b_ff, p0_b_in;

   // log read stage
   logic                p1_valid_ff, p1_valid_in;
   cmd_type             p1_cmd_ff, p1_cmd_in;
   logic [SYM_BITS-1:0] p1_a_ff, p1_a_in;
   logic                p1_zero_ff, p1_zero_in;
   logic                p1_dz_ff, p1_dz_in;

   // antilog read stage
   logic                p2_valid_ff, p2_valid_in;
   cmd_type             p2_cmd_ff, p2_cmd_in;
   logic [SYM_BITS-1:0] p2_a_ff, p2_a_in;
   logic                p2_zero_ff, p2_zero_in;
   logic                p2_dz_ff, p2_dz_in;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SYM_BITS-1:0] rsp_value_ff, rsp_value_in;
   logic                rsp_dz_ff, rsp_dz_in;

   logic                stall;
   logic                hazard;
   logic                p0_go;
   logic                req_take;
   logic                p1_acc_wr;
   logic                p2_acc_wr;
   logic [SYM_BITS-1:0] log_addr_a;
   logic [SYM_BITS-1:0] log_rd_a;
   logic [SYM_BITS-1:0] log_rd_b;
   logic [SYM_BITS:0]   exp_sum;
   logic [SYM_BITS:0]   exp_red;
   logic [SYM_BITS-1:0] alog_addr;
   logic [SYM_BITS-1:0] alog_rd;
   logic                opa_zero;
   logic                opb_zero;
   logic [SYM_BITS-1:0] prod;

   // ---------------------------------------------------------------------
   // configuration and field width
   // ---------------------------------------------------------------------
   assign csr_ready = 1'b1;
   assign restart   = csr_valid && (csr_index == CSR_FIELD_POLYNOMIAL ||
                                    csr_index == CSR_SYMBOL_BITS);

   always_comb begin
      poly_in = poly_ff;
      sym_in  = sym_ff;
      if (csr_valid && csr_index == CSR_FIELD_POLYNOMIAL) begin
         poly_in = csr_wdata;
      end
      if (csr_valid && csr_index == CSR_SYMBOL_BITS) begin
         sym_in = csr_wdata[WIDTH_BITS-1:0];
      end
   end

   // width clamped to 2 .. MAX_SYMBOL_BITS
   always_comb begin
      priority if (sym_ff < WIDTH_BITS'(2)) begin
         m_w = WIDTH_BITS'(2);
      end else if (sym_ff > WIDTH_BITS'(MAX_SYMBOL_BITS)) begin
         m_w = WIDTH_BITS'(MAX_SYMBOL_BITS);
      end else begin
         m_w = sym_ff;
      end
   end

   assign m_less1 = m_w - 1'b1;
   assign ms_full = ((SYM_BITS+1)'(1) << m_w) - 1'b1;
   assign ms      = ms_full[SYM_BITS-1:0];
   assign acc_m   = acc_ff & ms;

   // ---------------------------------------------------------------------
   // table builder and tables; the log table has two copies for two reads
   // ---------------------------------------------------------------------
   gfla_table_builder u_builder (
      .clock   (clock),
      .reset   (reset),
      .start   (restart),
      .poly    (poly_ff[SYM_BITS-1:0] & ms),
      .ms      (ms),
      .top_bit (m_less1[2:0]),
      .tbl_wr  (tbl_wr)
   );

   gfla_ram #(.WIDTH(SYM_BITS), .DEPTH(TBL_DEPTH)) u_log_a (
      .clock   (clock),
      .wr_en   (tbl_wr.log_we),
      .wr_addr (tbl_wr.log_addr),
      .wr_data (tbl_wr.log_data),
      .rd_en   (!stall),
      .rd_addr (log_addr_a),
      .rd_data (log_rd_a)
   );

   gfla_ram #(.WIDTH(SYM_BITS), .DEPTH(TBL_DEPTH)) u_log_b (
      .clock   (clock),
      .wr_en   (tbl_wr.log_we),
      .wr_addr (tbl_wr.log_addr),
      .wr_data (tbl_wr.log_data),
      .rd_en   (!stall),
      .rd_addr (p0_b_ff),
      .rd_data (log_rd_b)
   );

   // antilog entries 0 and 2^m - 1 hold 1; exponents above wrap by 2^m - 1
   gfla_ram #(.WIDTH(SYM_BITS), .DEPTH(TBL_DEPTH)) u_alog (
      .clock   (clock),
      .wr_en   (tbl_wr.alog_we),
      .wr_addr (tbl_wr.alog_addr),
      .wr_data (tbl_wr.alog_data),
      .rd_en   (!stall),
      .rd_addr (alog_addr),
      .rd_data (alog_rd)
   );

   // ---------------------------------------------------------------------
   // handshake and pipeline control
   // ---------------------------------------------------------------------
   assign stall     = rsp_valid_ff && !rsp_tready;
   assign p1_acc_wr = p1_valid_ff && (p1_cmd_ff == CMD_LOAD || p1_cmd_ff == CMD_HORNER);
   assign p2_acc_wr = p2_valid_ff && (p2_cmd_ff == CMD_LOAD || p2_cmd_ff == CMD_HORNER);
   // a horner step reads the accumulator only once older writers have left
   assign hazard    = (p0_cmd_ff == CMD_HORNER) && (p1_acc_wr || p2_acc_wr);
   assign p0_go     = p0_valid_ff && !stall && !hazard;
   assign req_tready = tbl_wr.ready && (!p0_valid_ff || p0_go);
   assign req_take   = req_tvalid && req_tready;

   // ---------------------------------------------------------------------
   // issue stage: operands masked on entry, log reads issued
   // ---------------------------------------------------------------------
   always_comb begin
      p0_valid_in = p0_valid_ff;
      p0_cmd_in   = p0_cmd_ff;
      p0_a_in     = p0_a_ff;
      p0_b_in     = p0_b_ff;
      if (req_take) begin
         p0_valid_in = 1'b1;
         p0_cmd_in   = cmd_type'(req_tuser);
         p0_a_in     = req_tdata[7:0] & ms;
         p0_b_in     = req_tdata[15:8] & ms;
      end else if (p0_go) begin
         p0_valid_in = 1'b0;
      end
   end

   assign log_addr_a = (p0_cmd_ff == CMD_HORNER) ? acc_m : p0_a_ff;
   assign opa_zero   = (log_addr_a == '0);
   assign opb_zero   = (p0_b_ff == '0);

   always_comb begin
      p1_valid_in = p1_valid_ff;
      p1_cmd_in   = p1_cmd_ff;
      p1_a_in     = p1_a_ff;
      p1_zero_in  = p1_zero_ff;
      p1_dz_in    = p1_dz_ff;
      if (!stall) begin
         p1_valid_in = p0_go;
         p1_cmd_in   = p0_cmd_ff;
         p1_a_in     = p0_a_ff;
         p1_zero_in  = opa_zero || opb_zero;
         p1_dz_in    = (p0_cmd_ff == CMD_DIV) && opb_zero;
      end
   end

   // ---------------------------------------------------------------------
   // log stage: exponent sum or difference, reduced mod 2^m - 1
   // ---------------------------------------------------------------------
   always_comb begin
      unique case (p1_cmd_ff)
         CMD_DIV: exp_sum = {1'b0, log_rd_a} + {1'b0, ms} - {1'b0, log_rd_b};
         default: exp_sum = {1'b0, log_rd_a} + {1'b0, log_rd_b};
      endcase
   end

   assign exp_red   = (exp_sum > {1'b0, ms}) ? (exp_sum - {1'b0, ms}) : exp_sum;
   assign alog_addr = exp_red[SYM_BITS-1:0];

   always_comb begin
      p2_valid_in = p2_valid_ff;
      p2_cmd_in   = p2_cmd_ff;
      p2_a_in     = p2_a_ff;
      p2_zero_in  = p2_zero_ff;
      p2_dz_in    = p2_dz_ff;
      if (!stall) begin
         p2_valid_in = p1_valid_ff;
         p2_cmd_in   = p1_cmd_ff;
         p2_a_in     = p1_a_ff;
         p2_zero_in  = p1_zero_ff;
         p2_dz_in    = p1_dz_ff;
      end
   end

   // ---------------------------------------------------------------------
   // antilog stage: result, accumulator update
   // ---------------------------------------------------------------------
   assign prod = p2_zero_ff ? '0 : alog_rd;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_dz_in    = rsp_dz_ff;
      acc_in       = acc_ff;
      if (!stall) begin
         rsp_valid_in = p2_valid_ff;
         rsp_dz_in    = p2_dz_ff;
         unique case (p2_cmd_ff)
            CMD_LOAD:   rsp_value_in = p2_a_ff;
            CMD_HORNER: rsp_value_in = prod ^ p2_a_ff;
            default:    rsp_value_in = prod;
         endcase
         if (p2_acc_wr) begin
            acc_in = rsp_value_in;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_dz_ff;

   // ---------------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         poly_ff      <= POLY_BITS'(285);
         sym_ff       <= WIDTH_BITS'(8);
         acc_ff       <= '0;
         p0_valid_ff  <= 1'b0;
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         poly_ff      <= poly_in;
         sym_ff       <= sym_in;
         acc_ff       <= acc_in;
         p0_valid_ff  <= p0_valid_in;
         p1_valid_ff  <= p1_valid_in;
         p2_valid_ff  <= p2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      p0_cmd_ff    <= p0_cmd_in;
      p0_a_ff      <= p0_a_in;
      p0_b_ff      <= p0_b_in;
      p1_cmd_ff    <= p1_cmd_in;
      p1_a_ff      <= p1_a_in;
      p1_zero_ff   <= p1_zero_in;
      p1_dz_ff     <= p1_dz_in;
      p2_cmd_ff    <= p2_cmd_in;
      p2_a_ff      <= p2_a_in;
      p2_zero_ff   <= p2_zero_in;
      p2_dz_ff     <= p2_dz_in;
      rsp_value_ff <= rsp_value_in;
      rsp_dz_ff    <= rsp_dz_in;
   end

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   // no request is taken while the tables are being built
   a_no_take_during_build: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> tbl_wr.ready)
      else $error("request taken while tables not ready");

   // a divide by zero result carries the value zero
   a_dz_value_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == '0))
      else $error("divide by zero result with nonzero value");

   // only a divide raises the divide by zero flag
   a_dz_only_div: assert property (@(posedge clock) disable iff (reset)
      (p2_valid_ff && p2_dz_ff) |-> (p2_cmd_ff == CMD_DIV))
      else $error("divide by zero flag on a non-divide item");

   // a horner step never leaves issue while an accumulator writer is in flight
   a_horner_interlock: assert property (@(posedge clock) disable iff (reset)
      (p1_valid_ff && p1_cmd_ff == CMD_HORNER) |-> !p2_acc_wr)
      else $error("horner step overlapped an accumulator write");

endmodule

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the gf(2^m) log/antilog arithmetic unit
// ----------------------------------------------------------------------------
// keeps its own copy of the field tables and the horner accumulator, and
// predicts each result when its request item is accepted. runs a directed set
// at the reset field, then walks many polynomial and width settings with
// random commands and horner chains. sender gaps and receiver stalls change
// from phase to phase, and one long receiver hold-off fills the pipeline.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import gfla_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 300;

   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] a;
      logic [7:0] b;
   } gf_op_type;

   typedef struct packed {
      logic [7:0] value;
      logic       div_by_zero;
   } gf_result_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   // dut inputs, all known from time zero
   logic                      csr_valid  = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index  = '0;
   logic [POLY_BITS-1:0]      csr_wdata  = '0;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [15:0]               req_tdata  = '0;   // operand_a, operand_b
   logic [1:0]                req_tuser  = '0;   // command
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [7:0]                rsp_tdata;         // value
   logic                      rsp_tuser;         // divide_by_zero

   // stimulus side
   gf_op_type     cmd_queue[$];        // items waiting for the driver
   gf_op_type     op_on_bus;           // item currently offered on req
   gf_result_type pending_results[$];  // predicted results, oldest first
   int            send_idle_pct = 0;
   int            stall_pct     = 0;
   logic          hold_rsp      = 1'b0;
   int            error_count   = 0;
   int            cycle_count   = 0;

   // predictor copy of the field state
   logic [8:0] field_poly;
   logic [3:0] width_reg;
   logic [7:0] horner_acc;
   logic [7:0] alog_tbl[512];
   logic [7:0] log_tbl[256];

   gf_log_antilog_arithmetic_unit dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // field model
   // ---------------------------------------------------------------------

   // symbol width as the hardware uses it, clamped to 2..MAX_SYMBOL_BITS
   function automatic int eff_width();
      int m;
      m = width_reg;
      if (m < 2) m = 2;
      if (m > MAX_SYMBOL_BITS) m = MAX_SYMBOL_BITS;
      return m;
   endfunction

   function automatic int field_mask();
      return (1 << eff_width()) - 1;
   endfunction

   // shift-and-reduce walk over alpha^i; the x^m term of the polynomial is
   // implied, so a polynomial without its top bit still builds something
   function automatic void build_field_tables();
      int m;
      int ms;
      int poly;
      int x;
      int carry;
      m    = eff_width();
      ms   = field_mask();
      poly = field_poly & ms;
      x    = 1;
      for (int i = 0; i < 512; i++) alog_tbl[i] = 8'd1;
      for (int i = 0; i < 256; i++) log_tbl[i] = 8'd0;
      for (int i = 1; i < ms; i++) begin
         carry = (x >> (m - 1)) & 1;
         x = ((x << 1) & ms) ^ (carry ? poly : 0);
         alog_tbl[i] = x[7:0];
         // later steps win when a non-primitive polynomial revisits an element
         log_tbl[x]  = i[7:0];
      end
      log_tbl[0] = ms[7:0];
      // second lap so that log sums need no modulo
      for (int i = ms + 1; i < (ms + 1) * 2; i++) alog_tbl[i] = alog_tbl[i - ms];
   endfunction

   function automatic logic [7:0] gf_product(logic [7:0] a, logic [7:0] b);
      int s;
      if (a == 0 || b == 0) return 8'd0;
      s = int'(log_tbl[a]) + int'(log_tbl[b]);
      return alog_tbl[s & 511];
   endfunction

   function automatic logic [7:0] gf_quotient(logic [7:0] a, logic [7:0] b);
      int s;
      if (a == 0 || b == 0) return 8'd0;
      s = int'(log_tbl[a]) + field_mask() - int'(log_tbl[b]);
      return alog_tbl[s & 511];
   endfunction

   // result of one command; load and horner update the accumulator
   function automatic gf_result_type gf_result_of(gf_op_type op);
      int            ms;
      logic [7:0]    a;
      logic [7:0]    b;
      gf_result_type r;
      ms = field_mask();
      a  = op.a & ms[7:0];
      b  = op.b & ms[7:0];
      r  = '0;
      case (op.cmd)
         CMD_MUL: begin
            r.value = gf_product(a, b);
         end
         CMD_DIV: begin
            if (b == 0) r.div_by_zero = 1'b1;
            else r.value = gf_quotient(a, b);
         end
         CMD_LOAD: begin
            horner_acc = a;
            r.value    = a;
         end
         default: begin
            // accumulator survives width changes, masked when read
            horner_acc = (gf_product(horner_acc & ms[7:0], b) ^ a) & ms[7:0];
            r.value    = horner_acc;
         end
      endcase
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // request driver: offers queued items, predicts each one on acceptance
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      logic accepted;
      logic take_next;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         accepted = req_tvalid && req_tready;
         if (accepted) pending_results.push_back(gf_result_of(op_on_bus));
         take_next = (!req_tvalid || req_tready) && cmd_queue.size() > 0 &&
                     ($urandom_range(99) >= send_idle_pct);
         if (take_next) begin
            op_on_bus  = cmd_queue.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= {op_on_bus.b, op_on_bus.a};
            req_tuser  <= op_on_bus.cmd;
         end else if (accepted) begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // result side backpressure; hold_rsp forces a long stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !hold_rsp && ($urandom_range(99) >= stall_pct);
      end
   end

   // result monitor: compare each accepted item with the oldest prediction
   always @(posedge clock) begin
      gf_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result item: value %0h divide_by_zero %0b",
                   rsp_tdata, rsp_tuser);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata !== want.value) begin
               $error("value: expected %0h, got %0h", want.value, rsp_tdata);
               error_count++;
            end
            if (rsp_tuser !== want.div_by_zero) begin
               $error("divide_by_zero: expected %0b, got %0b",
                      want.div_by_zero, rsp_tuser);
               error_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("gf_log_antilog_arithmetic_unit test failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------
   task automatic push_op(cmd_type cmd, logic [7:0] a, logic [7:0] b);
      gf_op_type op;
      op.cmd = cmd;
      op.a   = a;
      op.b   = b;
      cmd_queue.push_back(op);
   endtask

   // operands lean on zero, one and the top symbol; wide bits stay random
   function automatic logic [7:0] pick_symbol();
      case ($urandom_range(9))
         0:       return 8'h00;
         1:       return 8'h01;
         2:       return 8'(field_mask());
         3:       return 8'hff;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // mostly horner chains (load then steps), the rest single commands
   task automatic queue_random_ops(int n);
      int left;
      left = n;
      while (left > 0) begin
         if ($urandom_range(9) < 4) begin
            push_op(CMD_LOAD, pick_symbol(), pick_symbol());
            left--;
            for (int k = $urandom_range(1, 6); k > 0 && left > 0; k--) begin
               push_op(CMD_HORNER, pick_symbol(), pick_symbol());
               left--;
            end
         end else begin
            push_op(cmd_type'($urandom_range(3)), pick_symbol(), pick_symbol());
            left--;
         end
      end
   endtask

   // all items sent and answered, then the pipeline is left to settle
   task automatic wait_idle();
      while (cmd_queue.size() != 0 || pending_results.size() != 0 || req_tvalid)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // one csr write; the predictor rebuilds its tables along with the dut
   task automatic write_csr(logic [CSR_INDEX_BITS-1:0] idx, logic [POLY_BITS-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_FIELD_POLYNOMIAL) begin
         field_poly = data;
         build_field_tables();
      end else if (idx == CSR_SYMBOL_BITS) begin
         width_reg = data[3:0];
         build_field_tables();
      end
   endtask

   initial begin
      logic [8:0] polys[14];
      logic [3:0] widths[14];
      logic [3:0] w;

      // reset field: x^8+x^4+x^3+x^2+1, 8-bit symbols
      field_poly = 9'd285;
      width_reg  = 4'd8;
      horner_acc = 8'd0;
      build_field_tables();

      // settings walked by the random part: every width, out-of-range widths,
      // zero, all-ones, non-primitive and top-bit-less polynomials
      polys  = '{9'h007, 9'h00b, 9'h013, 9'h025, 9'h043, 9'h089, 9'h11d,
                 9'h12b, 9'h1ff, 9'h000, 9'h11b, 9'h01d, 9'h00d, 9'h000};
      widths = '{4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8,
                 4'd0, 4'd15, 4'd8, 4'd8, 4'd9, 4'd1, 4'd0};
      // last slot gets a random setting
      polys[13]  = 9'($urandom_range(511));
      widths[13] = 4'($urandom_range(15));

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed set at the reset field
      push_op(CMD_HORNER, 8'h07, 8'h09);  // step on the cleared accumulator
      push_op(CMD_MUL,    8'h00, 8'hff);
      push_op(CMD_MUL,    8'hff, 8'h00);
      push_op(CMD_MUL,    8'hff, 8'hff);
      push_op(CMD_MUL,    8'h01, 8'h01);
      push_op(CMD_MUL,    8'h02, 8'h80);
      push_op(CMD_MUL,    8'h53, 8'hca);
      push_op(CMD_DIV,    8'h37, 8'h00);  // divide by zero
      push_op(CMD_DIV,    8'h00, 8'h00);
      push_op(CMD_DIV,    8'h00, 8'h05);
      push_op(CMD_DIV,    8'hff, 8'hff);
      push_op(CMD_DIV,    8'h01, 8'hff);
      push_op(CMD_DIV,    8'h01, 8'h02);
      push_op(CMD_LOAD,   8'hff, 8'h00);
      push_op(CMD_HORNER, 8'h00, 8'hff);
      push_op(CMD_HORNER, 8'hff, 8'h00);
      push_op(CMD_HORNER, 8'h12, 8'h34);
      push_op(CMD_HORNER, 8'hab, 8'h01);
      push_op(CMD_LOAD,   8'h00, 8'hff);
      push_op(CMD_HORNER, 8'h55, 8'haa);
      push_op(CMD_LOAD,   8'ha5, 8'h5a);  // carried into the hold-off phase
      wait_idle();

      // long receiver hold-off while the sender keeps offering
      queue_random_ops(40);
      hold_rsp = 1'b1;
      repeat (HOLD_CYCLES) @(negedge clock);
      hold_rsp = 1'b0;
      wait_idle();

      // random phases over the field settings
      for (int p = 0; p < 14; p++) begin
         write_csr(CSR_FIELD_POLYNOMIAL, polys[p]);
         w = widths[p];
         // bits above the width field ride along in the write data
         write_csr(CSR_SYMBOL_BITS, {5'($urandom_range(31)), w});
         // writes to unused indexes must leave the field alone
         if (p % 5 == 2)
            write_csr(4'($urandom_range(2, 15)), 9'($urandom_range(511)));
         if (p == 3) write_csr(4'd15, 9'h1ff);
         @(negedge clock);
         case (p % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 61; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 61; end
            default: begin send_idle_pct = 32; stall_pct = 32; end
         endcase
         // first step reads the accumulator left from the old width
         push_op(CMD_HORNER, pick_symbol(), pick_symbol());
         queue_random_ops(35);
         wait_idle();
      end

      repeat (6) @(negedge clock);
      if (error_count == 0) begin
         $display("gf_log_antilog_arithmetic_unit test passed");
      end else begin
         $display("gf_log_antilog_arithmetic_unit test failed");
      end
      $finish;
   end

endmodule
